>>> rtl/psat_pkg.sv
// Shared constants, codes and types of the per-source admission table.
`default_nettype none

package psat_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    // Field and register widths
    localparam int ADDR_W     = 32;
    localparam int SLOT_W     = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int STATUS_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_SOURCE_LIMIT = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET     = 7'd10;
    localparam logic [CFG_W-1:0] PER_SOURCE_LIMIT_RESET = 7'd2;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_LIMIT = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Access request from the control logic to the slot store
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic              wr_valid;
        logic [ADDR_W-1:0] wr_data;
    } store_req_t;

endpackage

`default_nettype wire

>>> rtl/per_source_admission_table.sv
// Top level of the per-source admission table: control, configuration and scan.
//
//  Channel   Handshake           Payload
//  --------  ------------------  ------------------------------------------
//  request   start / busy        operation, source_address, slot_number
//  result    done (one cycle)    status, granted_slot
//  config    wr_en               wr_index, wr_data
//
// A remove is handled directly: the result strobes in the cycle after acceptance.
// An add transaction scans n = min(active_slots, SLOT_COUNT) slots, one slot per cycle,
// through the single read port of the slot store, then decides; with n = 0 nothing is
// read and the scan state goes straight to the decision.
// Reset clears every slot's valid bit at once; no clearing pass is needed.
// The receiver cannot stall; busy is high only while an add scan runs.
`default_nettype none

module per_source_admission_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         operation,
    input  wire logic [psat_pkg::ADDR_W-1:0]  source_address,
    input  wire logic [psat_pkg::SLOT_W-1:0]  slot_number,
    output logic                              done,
    output logic [psat_pkg::STATUS_W-1:0]     status,
    output logic [psat_pkg::SLOT_W-1:0]       granted_slot,
    input  wire logic                         wr_en,
    input  wire logic [psat_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [psat_pkg::CFG_W-1:0]   wr_data
);
    import psat_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  active_slots_reg;
    logic [CFG_W-1:0]  per_source_limit_reg;

    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  same_reg, same_next;
    logic              have_free_reg, have_free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;

    store_req_t        store_req;
    logic [ADDR_W-1:0] rd_entry;
    logic [31:0]       free_ext;

    psat_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rd_entry (rd_entry)
    );

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg     <= ACTIVE_SLOTS_RESET;
            per_source_limit_reg <= PER_SOURCE_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ACTIVE_SLOTS:     active_slots_reg     <= wr_data;
                CFG_PER_SOURCE_LIMIT: per_source_limit_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Sequence requests: remove directly, scan for add, then decide
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        same_next      = same_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        addr_next      = addr_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;
        store_req      = '0;
        free_ext       = 32'(free_idx_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_REMOVE)
                    begin
                        // Empty the named slot if it exists
                        if (32'(slot_number) < 32'(SLOT_COUNT))
                        begin
                            store_req.wr_en    = 1'b1;
                            store_req.wr_addr  = IDX_W'(slot_number);
                            store_req.wr_valid = 1'b0;
                        end
                        done_next    = 1'b1;
                        status_next  = STATUS_OK;
                        granted_next = '0;
                    end
                    else
                    begin
                        addr_next      = source_address;
                        n_next         = (32'(active_slots_reg) > 32'(SLOT_COUNT)) ?
                                         CNT_W'(SLOT_COUNT) : CNT_W'(active_slots_reg);
                        issue_next     = '0;
                        same_next      = '0;
                        have_free_next = 1'b0;
                        free_idx_next  = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one slot read per cycle
                if (issue_reg < n_reg)
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = IDX_W'(issue_reg);
                    issue_next        = issue_reg + 1'b1;
                    pend_next         = 1'b1;
                end

                if (pend_reg)
                begin
                    // Note the first empty slot, count matching ones
                    if (rd_entry == '0)
                    begin
                        if (!have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_idx_next  = IDX_W'(issue_reg - 1'b1);
                        end
                    end
                    else if (rd_entry == addr_reg)
                    begin
                        same_next = same_reg + 1'b1;
                    end
                end
                else if (issue_reg == n_reg)
                begin
                    // Decide: limit first, then fullness, else grant
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (32'(same_reg) >= 32'(per_source_limit_reg))
                    begin
                        status_next  = STATUS_LIMIT;
                        granted_next = '0;
                    end
                    else if (!have_free_reg)
                    begin
                        status_next  = STATUS_FULL;
                        granted_next = '0;
                    end
                    else
                    begin
                        store_req.wr_en    = 1'b1;
                        store_req.wr_addr  = free_idx_reg;
                        store_req.wr_valid = 1'b1;
                        store_req.wr_data  = addr_reg;
                        status_next        = STATUS_OK;
                        granted_next       = free_ext[SLOT_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            n_reg     <= n_next;
        end
    end

    // Hold scan results and the result transaction payload
    always_ff @(posedge clk)
    begin
        same_reg      <= same_next;
        have_free_reg <= have_free_next;
        free_idx_reg  <= free_idx_next;
        addr_reg      <= addr_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;

    // A result transaction is only shown once the scan is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while scan still running");

    // The read counter never passes the scanned range
    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= n_reg))
        else $error("scan read counter beyond active range");

    // A read is outstanding only after one was issued
    a_pend_issue: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ((state_reg == ST_SCAN) && (issue_reg != '0)))
        else $error("read outstanding without an issued address");

    // Refused requests carry no slot number
    a_refuse_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != STATUS_OK)) |-> (granted_reg == '0))
        else $error("refused request returned a slot");

    // Leaving the scan always strobes a result
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (state_next == ST_IDLE)) |=> done_reg)
        else $error("scan ended without a result");

endmodule

`default_nettype wire

>>> rtl/psat_slot_store.sv
// Slot store: address memory with per-slot valid bits and a registered read.
`default_nettype none

module psat_slot_store (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire psat_pkg::store_req_t     req,
    output logic [psat_pkg::ADDR_W-1:0]   rd_entry
);
    import psat_pkg::*;

    logic [ADDR_W-1:0]     mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [ADDR_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;

    // Write the address array; contents are qualified by the valid bits
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Clear every slot at reset, then track occupancy on each write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= req.wr_valid;
        end
    end

    // Register the read data and its valid bit
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg  <= mem[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // An empty slot reads as address zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> tb/sv/psat_scoreboard.sv
// Result checker for the per-source admission table: tracks the slot table and compares results.
module psat_scoreboard (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            operation,
    input  wire logic [psat_pkg::ADDR_W-1:0]     source_address,
    input  wire logic [psat_pkg::SLOT_W-1:0]     slot_number,
    input  wire logic                            done,
    input  wire logic [psat_pkg::STATUS_W-1:0]   status,
    input  wire logic [psat_pkg::SLOT_W-1:0]     granted_slot,
    input  wire logic                            wr_en,
    input  wire logic [psat_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [psat_pkg::CFG_W-1:0]      wr_data,
    output int unsigned                          fail_count,
    output int unsigned                          outstanding
);
    import psat_pkg::*;

    typedef struct packed {
        status_t           status_code;
        logic [SLOT_W-1:0] slot;
    } outcome_t;

    // Shadow copy of the slot store and of the two registers
    logic [ADDR_W-1:0] slot_store [SLOT_COUNT];
    logic [CFG_W-1:0]  active_slots;
    logic [CFG_W-1:0]  source_limit;

    outcome_t    expected_outcomes [$];
    int unsigned errors_seen = 0;
    int unsigned queued = 0;

    assign fail_count  = errors_seen;
    assign outstanding = queued;

    // Work out the outcome of one transaction and update the shadow table
    function automatic outcome_t predict_admission(op_t op, logic [ADDR_W-1:0] addr,
                                                   logic [SLOT_W-1:0] slot);
        outcome_t res;
        int       scan_len;
        int       same;
        int       free_idx;
        res.status_code = STATUS_OK;
        res.slot        = '0;
        if (op == OP_REMOVE)
        begin
            // out-of-range slots are ignored, an empty slot stays empty
            if (int'(slot) < SLOT_COUNT)
                slot_store[slot] = '0;
            return res;
        end
        scan_len = (int'(active_slots) > SLOT_COUNT) ? SLOT_COUNT : int'(active_slots);
        same     = 0;
        free_idx = -1;
        for (int i = 0; i < scan_len; i++)
        begin
            if (slot_store[IDX_W'(i)] == '0)
            begin
                if (free_idx < 0)
                    free_idx = i;
            end
            else if (slot_store[IDX_W'(i)] == addr)
            begin
                same++;
            end
        end
        // limit wins over fullness; an address of zero leaves the slot empty
        if (same >= int'(source_limit))
            res.status_code = STATUS_LIMIT;
        else if (free_idx < 0)
            res.status_code = STATUS_FULL;
        else
        begin
            slot_store[IDX_W'(free_idx)] = addr;
            res.slot                     = free_idx[SLOT_W-1:0];
        end
        return res;
    endfunction

    // Compare results, track configuration, queue predictions
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        int unsigned errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_store[IDX_W'(i)] = '0;
            active_slots = ACTIVE_SLOTS_RESET;
            source_limit = PER_SOURCE_LIMIT_RESET;
            expected_outcomes.delete();
            queued <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d, granted_slot %0d",
                           status, granted_slot);
                    errs++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (status !== want.status_code)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status_code, status);
                        errs++;
                    end
                    if (granted_slot !== want.slot)
                    begin
                        $error("granted_slot mismatch: expected %0d, actual %0d",
                               want.slot, granted_slot);
                        errs++;
                    end
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    CFG_ACTIVE_SLOTS:     active_slots = wr_data;
                    CFG_PER_SOURCE_LIMIT: source_limit = wr_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_outcomes.push_back(predict_admission(op_t'(operation),
                                                              source_address, slot_number));
            queued      <= expected_outcomes.size();
            errors_seen <= errors_seen + errs;
        end
    end

endmodule

>>> tb/sv/tb_per_source_admission_table.sv
// Testbench top for the per-source admission table: stimulus, watchdog and verdict.
module tb_per_source_admission_table;
    import psat_pkg::*;

    localparam int ITEM_TARGET    = 1050;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 operation;
    logic [ADDR_W-1:0]    source_address;
    logic [SLOT_W-1:0]    slot_number;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    granted_slot;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned issued = 0;
    int unsigned quiet_cycles = 0;
    bit          no_gaps = 1'b0;

    per_source_admission_table DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .source_address (source_address),
        .slot_number    (slot_number),
        .done           (done),
        .status         (status),
        .granted_slot   (granted_slot),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data)
    );

    psat_scoreboard checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .source_address (source_address),
        .slot_number    (slot_number),
        .done           (done),
        .status         (status),
        .granted_slot   (granted_slot),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Hold one request on the port until the block takes it
    task automatic issue_request(op_t op, logic [ADDR_W-1:0] addr, logic [SLOT_W-1:0] slot);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation      <= op;
        source_address <= addr;
        slot_number    <= slot;
        start          <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        issued++;
    endtask

    // Drop start and wait until every result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles while idle
    task automatic configure(logic [CFG_W-1:0] slots, logic [CFG_W-1:0] limit);
        wr_en    <= 1'b1;
        wr_index <= CFG_ACTIVE_SLOTS;
        wr_data  <= slots;
        @(posedge clk);
        wr_index <= CFG_PER_SOURCE_LIMIT;
        wr_data  <= limit;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    initial
    begin
        logic [ADDR_W-1:0] pool [8];
        logic [ADDR_W-1:0] addr;
        logic [CFG_W-1:0]  slots_cfg;
        logic [CFG_W-1:0]  limit_cfg;
        int                pool_len;
        int                span;
        int                phase_len;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        operation      <= OP_ADD;
        source_address <= '0;
        slot_number    <= '0;
        wr_en          <= 1'b0;
        wr_index       <= CFG_ACTIVE_SLOTS;
        wr_data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, limit hit, empty address, removes
        issue_request(OP_ADD, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_ADD, 32'hFFFF_FFFF, 6'd63);
        issue_request(OP_ADD, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_ADD, 32'h0000_0000, 6'd0);
        issue_request(OP_ADD, 32'h8000_0001, 6'd0);
        issue_request(OP_REMOVE, 32'h0000_0000, 6'd63);
        issue_request(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_ADD, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_ADD, 32'h0000_0001, 6'd0);
        drain_results();
        // Directed: shrunken range is full, zero range, zero limit
        configure(7'd3, 7'd2);
        issue_request(OP_ADD, 32'h0000_0005, 6'd0);
        drain_results();
        configure(7'd0, 7'd1);
        issue_request(OP_ADD, 32'h0000_0005, 6'd0);
        issue_request(OP_ADD, 32'hFFFF_FFFF, 6'd0);
        drain_results();
        configure(7'd10, 7'd0);
        issue_request(OP_ADD, 32'h0000_0007, 6'd0);
        drain_results();
        // Directed: range above capacity, stale entries back in range
        configure(7'd127, 7'd127);
        issue_request(OP_ADD, 32'h0000_0007, 6'd0);
        drain_results();
        configure(7'd2, 7'd1);
        issue_request(OP_ADD, 32'hFFFF_FFFF, 6'd0);
        drain_results();

        // Random phases: new settings, small address pool, mostly adds
        while (issued < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       slots_cfg = 7'd0;
                1:       slots_cfg = 7'd1;
                2:       slots_cfg = 7'd64;
                3:       slots_cfg = 7'd127;
                default: slots_cfg = CFG_W'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       limit_cfg = 7'd0;
                1:       limit_cfg = 7'd1;
                2:       limit_cfg = 7'd127;
                3:       limit_cfg = 7'd64;
                default: limit_cfg = CFG_W'($urandom_range(1, 4));
            endcase
            configure(slots_cfg, limit_cfg);
            no_gaps  = ($urandom_range(0, 3) == 0);
            pool_len = $urandom_range(1, 6);
            for (int k = 0; k < pool_len; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       pool[3'(k)] = '0;
                    1:       pool[3'(k)] = '1;
                    default: pool[3'(k)] = $urandom;
                endcase
            end
            span      = (slots_cfg > 7'd64) ? 64 : int'(slots_cfg);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 6) == 0)
                    addr = $urandom;
                else
                    addr = pool[3'($urandom_range(0, pool_len - 1))];
                if ($urandom_range(0, 9) < 3)
                begin
                    // free mostly slots inside the scanned range
                    if (span == 0 || $urandom_range(0, 4) == 0)
                        issue_request(OP_REMOVE, addr, SLOT_W'($urandom_range(0, 63)));
                    else
                        issue_request(OP_REMOVE, addr, SLOT_W'($urandom_range(0, span - 1)));
                end
                else
                    issue_request(OP_ADD, addr, SLOT_W'($urandom_range(0, 63)));
            end
            drain_results();
        end

        // Let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
